### hdl/psyn_pkg.sv
`default_nettype none

package psyn_pkg;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int NOTE_W     = 7;
    localparam int VOL_W      = 16;
    localparam int ACTV_W     = 3;
    localparam int SAMPLE_BITS = 16;
    localparam int NOTE_MAX   = 127;
    localparam int NOTE_COUNT = 128;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;

    // gain and rounding
    localparam int AMP_Q15     = 13107;
    localparam int VOL_MIN     = 1638;
    localparam int VOL_RESET   = 16384;
    localparam int AMPVOL_W    = 30;
    localparam int ROUND_SHIFT = 30;
    localparam int SAMPLE_MAX  = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int SAMPLE_MIN  = -(2 ** (SAMPLE_BITS - 1));

    // sine table geometry
    localparam int SINE_TABLE_BITS = 10;
    localparam int QBITS = SINE_TABLE_BITS - 2;
    localparam int QLEN  = 2 ** QBITS;
    localparam int FBITS = SAMPLE_BITS - 1;
    localparam int Q_FRAC = 30;
    localparam longint Q30_ONE = 64'sd1073741824;

    // top octave increments, notes 116..127, in units of 2^-48 turn
    localparam int TOP_FRAC = 48;
    localparam logic [63:0] TOP_OCTAVE [12] = '{
        64'd42411929280414, 64'd44933873833175, 64'd47605781012846,
        64'd50436568061260, 64'd53435702467046, 64'd56613133495737,
        64'd59979525594770, 64'd63546091718990, 64'd67324741155730,
        64'd71328078591788, 64'd75569466860294, 64'd80063061198111
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } seq_state_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [NOTE_W-1:0] note_number;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] audio_sample;
        logic                          sample_valid;
        logic [ACTV_W-1:0]             active_voices;
    } result_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
    } mix_ctrl_t;

    // q30 product truncated toward zero
    function automatic longint mulq30(input longint a, input longint b);
        return (a * b) / Q30_ONE;
    endfunction

    // quarter-wave sine magnitude in q1.15 for a quarter-wave table position
    function automatic longint quarter_mag(input int pos);
        longint x;
        longint x2;
        longint p;
        longint y;
        longint mag;
        x = longint'(pos) <<< (Q_FRAC - QBITS);
        x2 = mulq30(x, x);
        p = -64'sd3864;
        p = 64'sd172272 + mulq30(x2, p);
        p = -64'sd5026995 + mulq30(x2, p);
        p = 64'sd85569305 + mulq30(x2, p);
        p = -64'sd693598673 + mulq30(x2, p);
        p = 64'sd1686629713 + mulq30(x2, p);
        y = mulq30(x, p);
        if (y < 0)
        begin
            y = 0;
        end
        mag = (y + (longint'(1) <<< (Q_FRAC - 1 - FBITS))) >>> (Q_FRAC - FBITS);
        if (mag > SAMPLE_MAX)
        begin
            mag = SAMPLE_MAX;
        end
        return mag;
    endfunction

    // per-sample phase step of a note, rounded half up
    function automatic logic [63:0] note_increment(input int note, input int pbits);
        int d;
        int oct;
        int idx;
        int sh;
        d = NOTE_MAX - note;
        oct = d / 12;
        idx = 11 - d % 12;
        sh = oct + TOP_FRAC - pbits;
        return (TOP_OCTAVE[idx] + (64'd1 << (sh - 1))) >> sh;
    endfunction

endpackage

`default_nettype wire

### hdl/psyn_voice_mem.sv
`default_nettype none

module psyn_voice_mem #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 31,
    parameter int AW    = 2
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/psyn_sine_rom.sv
`default_nettype none

module psyn_sine_rom (
    input  wire logic                                  clk,
    input  wire logic [psyn_pkg::SINE_TABLE_BITS-1:0]  idx,
    output logic signed [psyn_pkg::SAMPLE_BITS-1:0]    entry
);

    import psyn_pkg::*;

    localparam logic [FBITS-1:0] QPEAK = FBITS'(quarter_mag(QLEN));

    logic [FBITS-1:0] qtab [QLEN];
    logic [1:0]       quad;
    logic [QBITS-1:0] pos;
    logic [QBITS-1:0] addr;
    logic             peak;
    logic [FBITS-1:0] mag;
    logic signed [SAMPLE_BITS-1:0] mag_ext;

    // quarter-wave table built at elaboration
    for (genvar i = 0; i < QLEN; i++)
    begin : g_tab
        assign qtab[i] = FBITS'(quarter_mag(i));
    end

    // fold the index onto the quarter wave
    always_comb
    begin
        quad   = idx[SINE_TABLE_BITS-1 -: 2];
        pos    = idx[QBITS-1:0];
        addr   = quad[0] ? QBITS'(-pos) : pos;
        peak   = quad[0] && (pos == '0);
        mag    = peak ? QPEAK : qtab[addr];
        mag_ext = signed'({1'b0, mag});
    end

    // signed entry, sign by half wave
    always_ff @(posedge clk)
    begin
        entry <= quad[1] ? -mag_ext : mag_ext;
    end

endmodule

`default_nettype wire

### hdl/psyn_mixer.sv
`default_nettype none

module psyn_mixer #(
    parameter int VOICES = 4
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire psyn_pkg::mix_ctrl_t                 ctrl,
    input  wire logic signed [psyn_pkg::SAMPLE_BITS-1:0] entry,
    input  wire logic [psyn_pkg::AMPVOL_W-1:0]       amp_vol,
    output logic signed [psyn_pkg::SAMPLE_BITS-1:0]  sample
);

    import psyn_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + AMPVOL_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(VOICES) + 1;
    localparam int Q_W    = ACC_W - ROUND_SHIFT;
    localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(64'd1 << (ROUND_SHIFT - 1));
    localparam logic signed [Q_W-1:0]   Q_HI = Q_W'(SAMPLE_MAX);
    localparam logic signed [Q_W-1:0]   Q_LO = Q_W'(SAMPLE_MIN);

    logic signed [PROD_W-1:0] product_reg;
    logic signed [PROD_W-1:0] product_next;
    logic                     prod_v_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  biased;
    logic signed [Q_W-1:0]    q;

    // voice product and accumulate
    always_comb
    begin
        product_next = entry * signed'({1'b0, amp_vol});
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_v_reg)
        begin
            acc_next = acc_reg + ACC_W'(product_reg);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctrl.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
        acc_reg     <= acc_next;
    end

    // round half up, then saturate
    always_comb
    begin
        biased = acc_reg + BIAS;
        q = signed'(biased[ACC_W-1:ROUND_SHIFT]);
        if (q > Q_HI)
        begin
            sample = SAMPLE_BITS'(SAMPLE_MAX);
        end
        else if (q < Q_LO)
        begin
            sample = SAMPLE_BITS'(SAMPLE_MIN);
        end
        else
        begin
            sample = q[SAMPLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

### hdl/polyphonic_sine_synth.sv
// order: a sample tick or note-off gives its result after the single read port
// of the voice memory walks each voice and the four-stage mix pipeline drains;
// a note-on or unused code goes straight to the drain state; one item is in work
// at a time, so a new item is taken only once the last result has been loaded
// reset: voice flags and sequencer clear and master volume returns to 0.5 at once;
// the voice memory is not cleared, an entry's data is used only after a note-on
`default_nettype none

module polyphonic_sine_synth #(
    parameter int VOICES     = 4,
    parameter int PHASE_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire psyn_pkg::item_t               item,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output psyn_pkg::result_t                  result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [psyn_pkg::VOL_W-1:0]    cfg_data
);

    import psyn_pkg::*;

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MEM_W  = NOTE_W + PHASE_BITS;

    seq_state_t state_reg;
    seq_state_t state_next;

    logic [OP_W-1:0]    op_reg;
    logic [NOTE_W-1:0]  note_reg;
    logic [VIDX_W-1:0]  issue_reg;
    logic [VIDX_W-1:0]  issue_next;
    logic [VOICES-1:0]  active_reg;
    logic [VOICES-1:0]  active_next;
    logic               found_reg;
    logic               found_next;
    logic               s1_valid_reg;
    logic               s1_act_reg;
    logic [VIDX_W-1:0]  s1_voice_reg;
    logic               s2_valid_reg;
    logic               s2_act_reg;
    logic               s3_valid_reg;
    logic               result_valid_reg;
    logic               result_valid_next;
    result_t            result_reg;
    result_t            result_next;
    logic [AMPVOL_W-1:0] amp_vol_reg;
    logic [VOL_W-1:0]   vol_clamped;

    logic               accept;
    logic               load;
    logic               free_any;
    logic [VIDX_W-1:0]  free_idx;
    logic               on_wr;
    logic               wb;
    logic               off_hit;
    logic               mem_wr_en;
    logic [VIDX_W-1:0]  mem_wr_addr;
    logic [MEM_W-1:0]   mem_wr_data;
    logic [MEM_W-1:0]   mem_rd_data;
    logic [NOTE_W-1:0]  rd_note;
    logic [PHASE_BITS-1:0] rd_phase;
    logic signed [SAMPLE_BITS-1:0] sine_entry;
    logic signed [SAMPLE_BITS-1:0] mix_sample;
    mix_ctrl_t          mix_ctrl;

    logic [PHASE_BITS-1:0] inc_tab [NOTE_COUNT];

    // phase step per note, built at elaboration
    for (genvar i = 0; i < NOTE_COUNT; i++)
    begin : g_inc
        assign inc_tab[i] = PHASE_BITS'(note_increment(i, PHASE_BITS));
    end

    assign accept       = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign rd_note      = mem_rd_data[PHASE_BITS +: NOTE_W];
    assign rd_phase     = mem_rd_data[PHASE_BITS-1:0];

    // lowest free voice
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_any = 1'b1;
                free_idx = VIDX_W'(i);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        load       = 1'b0;
        issue_next = issue_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                issue_next = '0;
                if (item_valid)
                begin
                    case (item.operation) inside
                        OP_TICK, OP_NOTE_OFF: state_next = ST_SCAN;
                        default:              state_next = ST_DRAIN;
                    endcase
                end
            end
            ST_SCAN:
            begin
                issue_next = issue_reg + 1'b1;
                if (issue_reg == VIDX_W'(VOICES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg && !s3_valid_reg &&
                    (!result_valid_reg || result_ready))
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // voice updates and memory write port
    always_comb
    begin
        on_wr   = accept && (item.operation == OP_NOTE_ON) && free_any;
        wb      = s1_valid_reg && s1_act_reg && (op_reg == OP_TICK);
        off_hit = s1_valid_reg && s1_act_reg && (op_reg == OP_NOTE_OFF) &&
                  (rd_note == note_reg) && !found_reg;

        mem_wr_en   = on_wr || wb;
        mem_wr_addr = wb ? s1_voice_reg : free_idx;
        mem_wr_data = wb ? {rd_note, rd_phase + inc_tab[rd_note]}
                         : {item.note_number, {PHASE_BITS{1'b0}}};

        active_next = active_reg;
        if (on_wr)
        begin
            active_next[free_idx] = 1'b1;
        end
        if (off_hit)
        begin
            active_next[s1_voice_reg] = 1'b0;
        end

        found_next = found_reg;
        if (accept)
        begin
            found_next = 1'b0;
        end
        else if (off_hit)
        begin
            found_next = 1'b1;
        end

        mix_ctrl.clear  = accept;
        mix_ctrl.mul_en = s2_act_reg;
    end

    // result beat
    always_comb
    begin
        result_next.audio_sample  = (op_reg == OP_TICK) ? mix_sample : '0;
        result_next.sample_valid  = (op_reg == OP_TICK);
        result_next.active_voices = ACTV_W'($countones(active_reg));
        if (load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
        vol_clamped = (cfg_data < VOL_W'(VOL_MIN)) ? VOL_W'(VOL_MIN) : cfg_data;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            issue_reg        <= '0;
            active_reg       <= '0;
            found_reg        <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s1_act_reg       <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s2_act_reg       <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            amp_vol_reg      <= AMPVOL_W'(VOL_RESET * AMP_Q15);
        end
        else
        begin
            state_reg        <= state_next;
            issue_reg        <= issue_next;
            active_reg       <= active_next;
            found_reg        <= found_next;
            s1_valid_reg     <= (state_reg == ST_SCAN);
            s1_act_reg       <= active_reg[issue_reg];
            s2_valid_reg     <= s1_valid_reg;
            s2_act_reg       <= wb;
            s3_valid_reg     <= s2_valid_reg;
            result_valid_reg <= result_valid_next;
            if (cfg_valid)
            begin
                amp_vol_reg <= AMPVOL_W'(AMPVOL_W'(vol_clamped) * AMPVOL_W'(AMP_Q15));
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= item.operation;
            note_reg <= item.note_number;
        end
        s1_voice_reg <= issue_reg;
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    psyn_voice_mem #(
        .DEPTH (VOICES),
        .WIDTH (MEM_W),
        .AW    (VIDX_W)
    ) u_voice_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (state_reg == ST_SCAN),
        .rd_addr (issue_reg),
        .rd_data (mem_rd_data)
    );

    psyn_sine_rom u_sine_rom (
        .clk   (clk),
        .idx   (rd_phase[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .entry (sine_entry)
    );

    psyn_mixer #(
        .VOICES (VOICES)
    ) u_mixer (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mix_ctrl),
        .entry   (sine_entry),
        .amp_vol (amp_vol_reg),
        .sample  (mix_sample)
    );

endmodule

`default_nettype wire

### hdl/psyn_checker.sv
`default_nettype none

module psyn_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_ready,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire psyn_pkg::result_t result
);

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input taken while an item is in work");

    // note events carry a silent sample
    a_event_silent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.sample_valid |-> result.audio_sample == '0)
        else $error("note event result with nonzero sample");

endmodule

bind polyphonic_sine_synth psyn_checker u_checker (.*);

`default_nettype wire
